// ===== design/hfc_pkg.sv =====
// Package for the half/single float converter: field widths, opcodes and
// format constants. No dependencies.
`timescale 1ns / 1ps
package hfc_pkg;

   localparam int VALUE_W  = 32;
   localparam int RESULT_W = 32;

   // Direction of conversion
   typedef enum logic {
      OP_TO_HALF   = 1'b0,
      OP_TO_SINGLE = 1'b1
   } op_type;

   localparam logic [14:0] HALF_INF   = 15'h7c00;
   localparam logic [12:0] ROUND_TIE  = 13'h1000;
   localparam logic [7:0]  BIAS_DELTA = 8'd112;
   localparam logic [7:0]  SUB_EXP    = 8'd114;
   localparam logic [7:0]  EXP_MAX    = 8'hff;
   localparam logic [4:0]  HEXP_MAX   = 5'h1f;

endpackage

// ===== design/hfc_req_if.sv =====
// Request channel of the converter: valid/ready handshake carrying op and value.
// Depends on hfc_pkg.
`timescale 1ns / 1ps
interface hfc_req_if;
   import hfc_pkg::*;

   logic               valid;
   logic               ready;
   logic               op;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

// ===== design/hfc_rsp_if.sv =====
// Response channel of the converter: valid/ready handshake carrying result.
// Depends on hfc_pkg.
`timescale 1ns / 1ps
interface hfc_rsp_if;
   import hfc_pkg::*;

   logic                valid;
   logic                ready;
   logic [RESULT_W-1:0] result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

// ===== design/half_float_convert.sv =====
// Single/half precision converter, round to nearest even on narrowing.
// A request beat passes the input register, then the result register, on its
// way to response valid. Throughput: one beat per cycle while the response
// side is ready, set by the single conversion stage between the two registers.
// Reset (synchronous, active high) empties both stages; payload is not reset.
`timescale 1ns / 1ps
module half_float_convert (
   input  logic      clock,
   input  logic      reset,
   hfc_req_if.sink   req_bus,
   hfc_rsp_if.source rsp_bus
);
   import hfc_pkg::*;

   // Narrow a single pattern to half, ties to even
   function automatic logic [15:0] to_half(logic [31:0] x);
      logic        sgn;
      logic [7:0]  ex;
      logic [22:0] mant;
      logic [7:0]  d;
      logic [4:0]  sh;
      logic [24:0] sig;
      logic [24:0] q;
      logic [24:0] mask;
      logic [24:0] rem;
      logic [24:0] half;
      logic [12:0] low;
      logic [14:0] mag;
      sgn  = x[31];
      ex   = x[30:23];
      mant = x[22:0];
      sig  = {2'b01, mant};
      low  = mant[12:0];
      d    = '0;
      sh   = '0;
      q    = '0;
      mask = '0;
      rem  = '0;
      half = '0;
      mag  = '0;
      if (ex == EXP_MAX || ex >= BIAS_DELTA + 8'd31) begin
         mag = HALF_INF;
      end else if (ex == 8'd0) begin
         mag = '0;
      end else if (ex <= BIAS_DELTA) begin
         // half subnormal range, or flush to zero
         d = BIAS_DELTA - ex;
         if (d <= 8'd10) begin
            sh   = 5'(d) + 5'd14;
            q    = sig >> sh;
            mask = (25'd1 << sh) - 25'd1;
            rem  = sig & mask;
            half = 25'd1 << (sh - 5'd1);
            if (rem > half || (rem == half && q[0])) begin
               q = q + 25'd1;
            end
            mag = q[14:0];
         end
      end else begin
         // normal range; a carry out of the mantissa may reach infinity
         mag = {5'(ex - BIAS_DELTA), mant[22:13]};
         if (low > ROUND_TIE || (low == ROUND_TIE && mag[0])) begin
            mag = mag + 15'd1;
         end
      end
      return {sgn, mag};
   endfunction

   // Widen a half pattern to single exactly
   function automatic logic [31:0] to_single(logic [15:0] h);
      logic       sgn;
      logic [4:0] ex;
      logic [9:0] mant;
      logic [3:0] lz;
      logic [9:0] m;
      logic [7:0] e;
      logic [31:0] r;
      sgn  = h[15];
      ex   = h[14:10];
      mant = h[9:0];
      // leading-zero count: the highest set bit wins
      lz = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (mant[i]) begin
            lz = 4'(9 - i);
         end
      end
      m = mant << (lz + 4'd1);
      e = SUB_EXP - 8'd2 - {4'd0, lz};
      if (ex == 5'd0) begin
         if (mant == 10'd0) begin
            r = {sgn, 31'd0};
         end else begin
            r = {sgn, e, m, 13'd0};
         end
      end else if (ex == HEXP_MAX) begin
         r = {sgn, EXP_MAX, mant, 13'd0};
      end else begin
         r = {sgn, 8'({3'd0, ex}) + BIAS_DELTA, mant, 13'd0};
      end
      return r;
   endfunction

   logic               s1_valid_ff;
   op_type             s1_op_ff;
   logic [VALUE_W-1:0] s1_value_ff;
   logic                s2_valid_ff;
   op_type              s2_op_ff;
   logic [RESULT_W-1:0] s2_result_ff;
   logic [RESULT_W-1:0] s2_result_in;
   logic                s2_load;
   logic                s1_load;

   // Advance when the next stage is empty or draining
   assign s2_load       = !s2_valid_ff || rsp_bus.ready;
   assign s1_load       = !s1_valid_ff || s2_load;
   assign req_bus.ready = s1_load;

   // Convert the held beat
   always_comb begin
      case (s1_op_ff)
         OP_TO_HALF:   s2_result_in = {16'd0, to_half(s1_value_ff)};
         OP_TO_SINGLE: s2_result_in = to_single(s1_value_ff[15:0]);
         default:      s2_result_in = '0;
      endcase
   end

   // Stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Stage payload: hold while stalled
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_op_ff    <= op_type'(req_bus.op);
         s1_value_ff <= req_bus.value;
      end
      if (s2_load) begin
         s2_op_ff     <= s1_op_ff;
         s2_result_ff <= s2_result_in;
      end
   end

   assign rsp_bus.valid  = s2_valid_ff;
   assign rsp_bus.result = s2_result_ff;

`ifndef SYNTHESIS
   // A held beat moves to the output whenever the output stage can load
   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_load |=> rsp_bus.valid)
      else $error("held beat did not reach the output stage");

   // Half results keep the upper half clear
   a_half_upper_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && s2_op_ff == OP_TO_HALF |-> rsp_bus.result[31:16] == 16'd0)
      else $error("half result has upper bits set");

   // A draining output never blocks the request side
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.ready |-> req_bus.ready)
      else $error("request stalled while response side drains");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for half_float_convert: directed table then random beats, each
// result checked against its typed value or a bit-level single/half predictor.
// Depends on hfc_pkg, hfc_req_if, hfc_rsp_if and the converter RTL.
`timescale 1ns / 1ps
module tb;
   import hfc_pkg::*;

   localparam int RANDOM_ITEMS = 1575;
   localparam int CALM_ITEMS   = 200;
   localparam int DRAIN_AT     = 800;
   localparam int HOLD_AFTER   = 400;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 500;
   localparam int ROW_COUNT    = 25;

   typedef struct packed {
      op_type      op;
      logic [31:0] value;
      logic        pinned;
      logic [31:0] result;
   } stim_row_type;

   logic clock;
   logic reset;
   logic calm;
   logic offer_pinned;
   logic [31:0] offer_result;
   int results_seen;
   int fault_count;
   int idle_cycles;
   logic [31:0] awaited_results [$];

   hfc_req_if req_bus ();
   hfc_rsp_if rsp_bus ();

   half_float_convert uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Directed rows: typed results only where they are plain from the formats
   stim_row_type directed_rows [0:ROW_COUNT-1] = '{
      '{OP_TO_HALF,   32'h0000_0000, 1'b1, 32'h0000_0000},  // zero
      '{OP_TO_HALF,   32'h8000_0000, 1'b1, 32'h0000_8000},  // negative zero
      '{OP_TO_HALF,   32'h7f80_0000, 1'b1, 32'h0000_7c00},  // infinity
      '{OP_TO_HALF,   32'hff80_0000, 1'b1, 32'h0000_fc00},  // negative infinity
      '{OP_TO_HALF,   32'h7fc0_0001, 1'b1, 32'h0000_7c00},  // NaN loses payload
      '{OP_TO_HALF,   32'hffff_ffff, 1'b1, 32'h0000_fc00},  // negative NaN
      '{OP_TO_HALF,   32'h0000_0001, 1'b1, 32'h0000_0000},  // single subnormal
      '{OP_TO_HALF,   32'h807f_ffff, 1'b1, 32'h0000_8000},  // negative subnormal
      '{OP_TO_HALF,   32'h4780_0000, 1'b1, 32'h0000_7c00},  // exponent overflow
      '{OP_TO_HALF,   32'h477f_e000, 1'b1, 32'h0000_7bff},  // largest finite half
      '{OP_TO_HALF,   32'h477f_f000, 1'b1, 32'h0000_7c00},  // rounding carries to inf
      '{OP_TO_HALF,   32'h3380_0000, 1'b1, 32'h0000_0001},  // smallest half subnormal
      '{OP_TO_HALF,   32'h3300_0000, 1'b1, 32'h0000_0000},  // exact half of it, to even
      '{OP_TO_HALF,   32'h3300_0001, 1'b0, 32'h0},          // just above that
      '{OP_TO_HALF,   32'h3f80_1000, 1'b0, 32'h0},          // tie, even kept
      '{OP_TO_HALF,   32'h3f80_3000, 1'b0, 32'h0},          // tie, odd rounded up
      '{OP_TO_HALF,   32'h3800_0000, 1'b0, 32'h0},          // top of subnormal range
      '{OP_TO_HALF,   32'h387f_ffff, 1'b0, 32'h0},          // subnormal rounds to normal
      '{OP_TO_SINGLE, 32'h0000_0000, 1'b1, 32'h0000_0000},  // zero
      '{OP_TO_SINGLE, 32'h0000_8000, 1'b1, 32'h8000_0000},  // negative zero
      '{OP_TO_SINGLE, 32'hffff_3c00, 1'b1, 32'h3f80_0000},  // upper bits ignored
      '{OP_TO_SINGLE, 32'h0000_0001, 1'b1, 32'h3380_0000},  // smallest subnormal
      '{OP_TO_SINGLE, 32'h0000_03ff, 1'b0, 32'h0},          // largest subnormal
      '{OP_TO_SINGLE, 32'h0000_7c00, 1'b1, 32'h7f80_0000},  // infinity
      '{OP_TO_SINGLE, 32'h0000_fe01, 1'b1, 32'hffc0_2000}   // NaN keeps payload
   };

   // Narrow a single pattern to half, round to nearest even
   function automatic logic [15:0] narrowed_half(logic [31:0] x);
      logic [15:0] sgn;
      logic [7:0]  ex;
      logic [7:0]  d;
      logic [4:0]  sh;
      logic [31:0] sig;
      logic [31:0] q;
      logic [31:0] rem;
      logic [31:0] tie;
      logic [15:0] packed_half;
      sgn = {x[31], 15'b0};
      ex  = x[30:23];
      if (ex == EXP_MAX) return sgn | 16'(HALF_INF);
      if (ex == 8'd0) return sgn;
      if (ex >= BIAS_DELTA + 8'd31) return sgn | 16'(HALF_INF);
      if (ex <= BIAS_DELTA) begin
         d = BIAS_DELTA - ex;
         if (d > 8'd10) return sgn;
         sig = {9'b1, x[22:0]};
         sh  = 5'(d) + 5'd14;
         q   = sig >> sh;
         rem = sig & ((32'd1 << sh) - 32'd1);
         tie = 32'd1 << (sh - 5'd1);
         if (rem > tie || (rem == tie && q[0])) q = q + 32'd1;
         return sgn | q[15:0];
      end
      packed_half = {1'b0, 5'(ex - BIAS_DELTA), x[22:13]};
      if (x[12:0] > ROUND_TIE || (x[12:0] == ROUND_TIE && packed_half[0]))
         packed_half = packed_half + 16'd1;
      return sgn | packed_half;
   endfunction

   // Widen a half pattern to single, normalising subnormals
   function automatic logic [31:0] widened_single(logic [15:0] h);
      logic [4:0]  ex;
      logic [10:0] m;
      logic [7:0]  e;
      ex = h[14:10];
      if (ex == 5'd0) begin
         if (h[9:0] == 10'd0) return {h[15], 31'b0};
         m = {1'b0, h[9:0]};
         e = SUB_EXP - 8'd1;
         while (!m[10]) begin
            m = m << 1;
            e = e - 8'd1;
         end
         return {h[15], e, m[9:0], 13'b0};
      end
      if (ex == HEXP_MAX) return {h[15], EXP_MAX, h[9:0], 13'b0};
      return {h[15], 8'(8'(ex) + BIAS_DELTA), h[9:0], 13'b0};
   endfunction

   function automatic logic [31:0] converted_pattern(op_type op, logic [31:0] v);
      if (op == OP_TO_HALF) return {16'b0, narrowed_half(v)};
      return widened_single(v[15:0]);
   endfunction

   // Draw one random operand, weighted towards rounding edges and specials
   task automatic pick_operand(output op_type op, output logic [31:0] v);
      int d;
      op = op_type'($urandom_range(0, 1));
      v  = $urandom();
      if (op == OP_TO_HALF) begin
         case ($urandom_range(0, 9))
            0, 1: ;
            2, 3, 4: v[30:23] = 8'($urandom_range(98, 146));
            5: begin
               // tie region below the smallest normal half
               d = $urandom_range(0, 9);
               v = (v & ~((32'd1 << (14 + d)) - 32'd1))
                   | ((32'd1 << (13 + d)) + $urandom_range(0, 2) - 32'd1);
               v[30:23] = 8'(BIAS_DELTA - 8'(d));
            end
            6: begin
               v[30:23] = 8'($urandom_range(113, 142));
               case ($urandom_range(0, 3))
                  0: v[12:0] = ROUND_TIE;
                  1: v[12:0] = ROUND_TIE - 13'd1;
                  2: v[12:0] = ROUND_TIE + 13'd1;
                  default: v[12:0] = 13'h1fff;
               endcase
            end
            7: begin
               case ($urandom_range(0, 5))
                  0: v[30:23] = 8'd0;
                  1: v[30:23] = EXP_MAX;
                  2: v[30:23] = BIAS_DELTA + 8'd31;
                  3: v[30:23] = BIAS_DELTA;
                  4: v[30:23] = 8'd1;
                  default: v[30:23] = EXP_MAX - 8'd1;
               endcase
               if ($urandom_range(0, 3) == 0) v[22:0] = 23'd0;
            end
            default: v[30:23] = 8'($urandom_range(113, 142));
         endcase
      end else begin
         case ($urandom_range(0, 3))
            0: ;
            1: v[14:10] = 5'd0;
            2: v[14:10] = HEXP_MAX;
            default: v[9:0] = 10'd0;
         endcase
      end
   endtask

   // Offer one beat and hold it until the converter takes it
   task automatic offer_beat(op_type op, logic [31:0] v, logic pinned, logic [31:0] res);
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.value <= v;
      offer_pinned  <= pinned;
      offer_result  <= res;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid for a random burst now and then
   task automatic sender_gap();
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
   end

   always #2 clock = ~clock;

   // Sender: reset, directed table, random beats, drain
   initial begin : sender
      op_type      op;
      logic [31:0] v;
      reset         = 1'b1;
      calm          = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.op    = OP_TO_HALF;
      req_bus.value = '0;
      offer_pinned  = 1'b0;
      offer_result  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (reset);

      foreach (directed_rows[i]) begin
         sender_gap();
         offer_beat(directed_rows[i].op, directed_rows[i].value,
                    directed_rows[i].pinned, directed_rows[i].result);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == DRAIN_AT) begin
            // pause until every outstanding result has come back
            req_bus.valid <= 1'b0;
            do @(negedge clock); while (awaited_results.size() != 0);
            @(posedge clock);
         end
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
         sender_gap();
         pick_operand(op, v);
         offer_beat(op, v, 1'b0, 32'h0);
      end

      req_bus.valid <= 1'b0;
      do @(negedge clock); while (awaited_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fault_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Receiver: random stalls, one long hold-off to back the pipe up
   initial begin : receiver
      logic held_off;
      held_off      = 1'b0;
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held_off && results_seen >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin
      results_seen = 0;
      fault_count  = 0;
      idle_cycles  = 0;
   end

   // Track accepted beats: queue the expected result, check each response
   always @(posedge clock) begin : scoreboard
      logic [31:0] want;
      logic        took_req;
      logic        took_rsp;
      took_req = req_bus.valid && req_bus.ready;
      took_rsp = rsp_bus.valid && rsp_bus.ready;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (took_rsp) begin
            results_seen <= results_seen + 1;
            if (awaited_results.size() == 0) begin
               $error("result: no beat expected, actual %08h", rsp_bus.result);
               fault_count <= fault_count + 1;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_bus.result !== want) begin
                  $error("result: expected %08h, actual %08h", want, rsp_bus.result);
                  fault_count <= fault_count + 1;
               end
            end
         end
         if (took_req) begin
            awaited_results.push_back(offer_pinned ? offer_result :
               converted_pattern(op_type'(req_bus.op), req_bus.value));
         end
         // watchdog on cycles with no beat on either side
         if (took_req || took_rsp) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

endmodule

// ===== half_float_convert.f =====
design/hfc_pkg.sv
design/hfc_req_if.sv
design/hfc_rsp_if.sv
design/half_float_convert.sv
sim/tb.sv
